@@ src/u8dec_pkg.sv @@
// types and constants shared by the utf-8 decoder modules
package u8dec_pkg;

	// input word: one raw utf-8 byte and the end-of-string mark
	typedef struct packed {
		logic [7:0] data_byte;
		logic       string_end;
	} in_word_t;

	// output word: one decoded character
	typedef struct packed {
		logic [15:0] code_point;
		logic        malformed;
		logic        last_of_item;
	} out_word_t;

	// up to two characters produced by one byte
	typedef struct packed {
		logic      v0;
		logic      v1;
		out_word_t r0;
		out_word_t r1;
	} push_t;

	localparam logic [15:0] QMARK      = 16'h003F;
	localparam logic [15:0] MARK_VALUE = 16'hFEFF;
	localparam logic [7:0]  BOM_LEAD   = 8'hEF;

endpackage

@@ src/u8dec_core.sv @@
// decode state and per-byte decode logic of the utf-8 decoder
module u8dec_core
	import u8dec_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  in_word_t word,
	output push_t    push
);

	logic [15:0] pv_q;
	logic [1:0]  rem_q;
	logic        start_q;
	logic        mark_q;

	logic [15:0] n_pv;
	logic [1:0]  n_rem;
	logic        n_mark;
	logic [7:0]  b;
	logic        str_end;
	logic        cont;
	logic        pending;
	logic        f_v;
	logic [15:0] f_cp;
	logic        f_bad;
	logic        e0_v;
	logic [15:0] e0_cp;
	logic        e0_bad;
	logic        e1_v;
	logic [15:0] e1_cp;
	logic        e1_bad;

	assign b       = word.data_byte;
	assign str_end = word.string_end;
	assign cont    = (b[7:6] == 2'b10);
	assign pending = (rem_q != 2'd0);

	// next state and emitted characters for the held byte
	always_comb begin
		n_pv   = pv_q;
		n_rem  = rem_q;
		n_mark = mark_q;
		f_v    = 1'b0;
		f_cp   = QMARK;
		f_bad  = 1'b0;
		e0_v   = 1'b0;
		e0_cp  = QMARK;
		e0_bad = 1'b0;
		e1_v   = 1'b0;
		e1_cp  = QMARK;
		e1_bad = 1'b0;
		if (pending && cont) begin
			// continuation of the pending sequence
			n_pv  = {pv_q[9:0], b[5:0]};
			n_rem = rem_q - 2'd1;
			if (n_rem == 2'd0) begin
				if (!(mark_q && n_pv == MARK_VALUE)) begin
					e0_v  = 1'b1;
					e0_cp = n_pv;
				end
				n_mark = 1'b0;
			end else if (str_end) begin
				e0_v   = 1'b1;
				e0_bad = 1'b1;
				n_rem  = 2'd0;
				n_mark = 1'b0;
			end
		end else begin
			// a pending sequence cut by a non-continuation byte
			if (pending) begin
				n_rem  = 2'd0;
				n_mark = 1'b0;
			end
			// the byte handled as fresh
			case (b) inside
				[8'h00:8'h7F]: begin
					f_v  = 1'b1;
					f_cp = {8'h00, b};
				end
				[8'h80:8'hBF]: begin
					f_v = 1'b0;
				end
				[8'hC0:8'hDF]: begin
					if (str_end) begin
						f_v   = 1'b1;
						f_bad = 1'b1;
					end else begin
						n_pv   = {11'd0, b[4:0]};
						n_rem  = 2'd1;
						n_mark = 1'b0;
					end
				end
				[8'hE0:8'hEF]: begin
					if (str_end) begin
						f_v   = 1'b1;
						f_bad = 1'b1;
					end else begin
						n_pv   = {12'd0, b[3:0]};
						n_rem  = 2'd2;
						n_mark = start_q && (b == BOM_LEAD);
					end
				end
				default: begin
					f_v   = 1'b1;
					f_bad = 1'b1;
				end
			endcase
			if (pending) begin
				e0_v   = 1'b1;
				e0_bad = 1'b1;
				e1_v   = f_v;
				e1_cp  = f_cp;
				e1_bad = f_bad;
			end else begin
				e0_v   = f_v;
				e0_cp  = f_cp;
				e0_bad = f_bad;
			end
		end
		// string end returns to string start
		if (str_end) begin
			n_pv   = 16'd0;
			n_rem  = 2'd0;
			n_mark = 1'b0;
		end
	end

	// results handed to the queue
	always_comb begin
		push.v0              = fire && e0_v;
		push.v1              = fire && e1_v;
		push.r0.code_point   = e0_cp;
		push.r0.malformed    = e0_bad;
		push.r0.last_of_item = !e1_v;
		push.r1.code_point   = e1_cp;
		push.r1.malformed    = e1_bad;
		push.r1.last_of_item = 1'b1;
	end

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q    <= 16'd0;
			rem_q   <= 2'd0;
			start_q <= 1'b1;
			mark_q  <= 1'b0;
		end else if (fire) begin
			pv_q    <= n_pv;
			rem_q   <= n_rem;
			start_q <= str_end;
			mark_q  <= n_mark;
		end
	end

	// a second character only follows a cut sequence
	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0 && push.r0.malformed && !push.r0.last_of_item)
		else $error("second character without a malformed first");

	// the mark can only be pending inside a 3-byte sequence
	a_mark_in_seq: assert property (@(posedge clk) disable iff (!arst_n)
		mark_q |-> rem_q != 2'd0 && !start_q)
		else $error("mark candidate outside a pending sequence");

endmodule

@@ src/u8dec_fifo.sv @@
// small result queue: up to two words in, one word out per cycle
module u8dec_fifo
	import u8dec_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  push_t     push,
	output logic      room2,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	out_word_t          mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PTR_W-1:0]   wr_next;
	logic [PTR_W-1:0]   wr_next2;
	logic [PTR_W-1:0]   rd_next;
	logic               pop;
	logic [CNT_W-1:0]   n_push;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign wr_next   = ptr_inc(wr_q);
	assign wr_next2  = ptr_inc(wr_next);
	assign rd_next   = ptr_inc(rd_q);
	assign out_valid = (cnt_q != '0);
	assign out_word  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign room2     = (cnt_q <= CNT_W'(DEPTH - 2));
	assign n_push    = CNT_W'(push.v0) + CNT_W'(push.v1);

	// storage writes
	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wr_next] <= push.r1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.v1) begin
				wr_q <= wr_next2;
			end else if (push.v0) begin
				wr_q <= wr_next;
			end
			if (pop) begin
				rd_q <= rd_next;
			end
			cnt_q <= cnt_q + n_push - CNT_W'(pop);
		end
	end

	// never holds more than its depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("result queue overflow");

	// pushes only land where room was reported
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.v0 |-> room2)
		else $error("push into a full result queue");

endmodule

@@ src/utf8_to_ucs2_decoder.sv @@
// top level of the utf-8 to 16-bit code point decoder
// Accepts one utf-8 byte per cycle on a valid/ready channel and delivers decoded 16-bit
// characters on a second valid/ready channel. A byte is held in an input register, decoded
// by a single pass of logic against the sequence state, and its zero, one or two characters
// are written into a small result queue (Q_DEPTH words) that feeds the output port. Input
// rate is one byte per clock as long as the queue has room for two words; since the output
// port delivers one word per clock while out_ready is high, a two-character byte (a cut
// sequence followed by a fresh character) occupies the output longer. A byte is registered
// in the input register, then in the result queue, before its first character is valid.
// A leading EF BB BF at string start yields nothing, four-byte and invalid leads yield 0x3F
// flagged malformed, stray continuations are dropped, last_of_item marks a byte's final character.
module utf8_to_ucs2_decoder
	import u8dec_pkg::*;
#(
	parameter int Q_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	in_word_t word_s1;
	logic     valid_s1;
	logic     room2;
	logic     fire;
	push_t    push;

	// the held byte is decoded once the queue can take two words
	assign fire     = valid_s1 && room2;
	assign in_ready = !valid_s1 || room2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
		end
	end

	u8dec_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.word   (word_s1),
		.push   (push)
	);

	u8dec_fifo #(
		.DEPTH (Q_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	// a held byte waits unchanged while the queue is short of room
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room2 |=> valid_s1 && $stable(word_s1))
		else $error("held byte lost while stalled");

endmodule

@@ tb/sv/utf8_to_ucs2_decoder_test.sv @@
// self-checking testbench for the utf-8 to 16-bit code point decoder
`timescale 1ns / 1ps

module utf8_to_ucs2_decoder_test;
	import u8dec_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_word = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_word;

	// bytes waiting to be offered and characters the decoder still owes
	in_word_t  pending_bytes[$];
	out_word_t expected_chars[$];

	// shadow of the decoder's sequence state
	logic [15:0] seq_value;
	logic [1:0]  conts_due;
	logic        at_start;
	logic        bom_lead;

	int errors;
	int counted;
	int bytes_taken;
	int chars_seen;
	int bad_chars;
	int pair_bytes;
	int unsigned tx_gap, tx_pick;
	int unsigned rx_gap, rx_pick;
	int unsigned hold_left;
	bit          hold_done;

	utf8_to_ucs2_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, a few long ones, none at all in busy phases
	function automatic int unsigned pick_gap(input bit busy);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (busy || r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic out_word_t char_word(input logic [15:0] cp, input logic bad);
		out_word_t w;
		w.code_point   = cp;
		w.malformed    = bad;
		w.last_of_item = 1'b0;
		return w;
	endfunction

	// decode one accepted byte and queue the characters it must produce
	task automatic decode_byte(input in_word_t w);
		out_word_t chars[$];
		logic [7:0] b;
		logic       fin;
		logic       first;
		bit         taken;
		b = w.data_byte;
		fin = w.string_end;
		first = at_start;
		taken = 1'b0;

		// a sequence is open: extend it or cut it
		if (conts_due != 2'd0) begin
			if (b[7:6] == 2'b10) begin
				seq_value = {seq_value[9:0], b[5:0]};
				conts_due = conts_due - 2'd1;
				if (conts_due == 2'd0) begin
					if (!(bom_lead && seq_value == MARK_VALUE))
						chars.push_back(char_word(seq_value, 1'b0));
					bom_lead = 1'b0;
				end else if (fin) begin
					chars.push_back(char_word(QMARK, 1'b1));
					conts_due = 2'd0;
					bom_lead = 1'b0;
				end
				taken = 1'b1;
			end else begin
				chars.push_back(char_word(QMARK, 1'b1));
				conts_due = 2'd0;
				bom_lead = 1'b0;
			end
		end

		// fresh byte
		if (!taken) begin
			if (b[7] == 1'b0) begin
				chars.push_back(char_word({8'h00, b}, 1'b0));
			end else if (b[7:6] == 2'b10) begin
				// stray continuation, nothing comes out
			end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110) begin
				if (fin) begin
					chars.push_back(char_word(QMARK, 1'b1));
				end else if (b[7:5] == 3'b110) begin
					seq_value = {11'd0, b[4:0]};
					conts_due = 2'd1;
					bom_lead = 1'b0;
				end else begin
					seq_value = {12'd0, b[3:0]};
					conts_due = 2'd2;
					bom_lead = first && b == BOM_LEAD;
				end
			end else begin
				chars.push_back(char_word(QMARK, 1'b1));
			end
		end

		at_start = 1'b0;
		if (fin) begin
			seq_value = '0;
			conts_due = 2'd0;
			bom_lead = 1'b0;
			at_start = 1'b1;
		end
		if (chars.size() != 0)
			chars[chars.size() - 1].last_of_item = 1'b1;
		if (chars.size() == 2)
			pair_bytes++;
		foreach (chars[i])
			expected_chars.push_back(chars[i]);
	endtask

	task automatic put_byte(input logic [7:0] b, input logic fin);
		in_word_t w;
		w.data_byte = b;
		w.string_end = fin;
		pending_bytes.push_back(w);
		counted++;
	endtask

	// one random string: mostly well-formed characters, some broken or noisy bytes
	task automatic add_string();
		logic [7:0] text[$];
		in_word_t   w;
		logic [31:0] rnd;
		int unsigned nchar, kind, k;
		bit with_bom;
		with_bom = ($urandom_range(0, 4) == 0);
		if (with_bom) begin
			text.push_back(8'hEF);
			text.push_back(8'hBB);
			if ($urandom_range(0, 3) != 0)
				text.push_back(8'hBF);
		end
		nchar = $urandom_range(with_bom ? 0 : 1, 10);
		for (int i = 0; i < nchar; i++) begin
			kind = $urandom_range(0, 99);
			rnd = $urandom;
			if (kind < 30) begin
				text.push_back({1'b0, rnd[6:0]});
			end else if (kind < 50) begin
				text.push_back({3'b110, rnd[4:0]});
				text.push_back({2'b10, rnd[10:5]});
			end else if (kind < 72) begin
				text.push_back({4'b1110, rnd[3:0]});
				text.push_back({2'b10, rnd[9:4]});
				text.push_back({2'b10, rnd[15:10]});
			end else if (kind < 80) begin
				k = $urandom_range(0, 2);
				if (k == 0)
					text.push_back({3'b110, rnd[4:0]});
				else
					text.push_back({4'b1110, rnd[3:0]});
				if (k == 2)
					text.push_back({2'b10, rnd[9:4]});
			end else if (kind < 85) begin
				// four-byte lead: its continuations fall out as strays
				text.push_back({5'b11110, rnd[2:0]});
				text.push_back({2'b10, rnd[8:3]});
				text.push_back({2'b10, rnd[14:9]});
				text.push_back({2'b10, rnd[20:15]});
			end else if (kind < 90) begin
				text.push_back({5'b11111, rnd[2:0]});
			end else if (kind < 94) begin
				text.push_back({2'b10, rnd[5:0]});
			end else begin
				text.push_back(rnd[7:0]);
			end
		end
		foreach (text[i]) begin
			w.data_byte = text[i];
			w.string_end = (i == text.size() - 1);
			pending_bytes.push_back(w);
			counted++;
		end
	endtask

	// sender: offers queued bytes with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap <= 0;
		end else if (in_valid && in_ready) begin
			decode_byte(in_word);
			bytes_taken <= bytes_taken + 1;
			tx_pick = pick_gap((bytes_taken % 512) < 128);
			if (tx_pick == 0 && pending_bytes.size() != 0) begin
				in_word <= pending_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
				tx_gap <= tx_pick;
			end
		end else if (!in_valid) begin
			if (tx_gap != 0) begin
				tx_gap <= tx_gap - 1;
			end else if (pending_bytes.size() != 0) begin
				in_word <= pending_bytes.pop_front();
				in_valid <= 1'b1;
			end
		end
	end

	// receiver: random stalls plus one long hold-off to back the decoder up
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_gap <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && chars_seen >= 300) begin
			hold_left <= 400;
			hold_done <= 1'b1;
			out_ready <= 1'b0;
		end else if (rx_gap != 0) begin
			rx_gap <= rx_gap - 1;
			out_ready <= 1'b0;
		end else if (out_valid && out_ready) begin
			rx_pick = pick_gap((chars_seen % 512) >= 256 && (chars_seen % 512) < 384);
			out_ready <= (rx_pick == 0);
			if (rx_pick != 0)
				rx_gap <= rx_pick - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// checker: every delivered word against the oldest expected character
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			chars_seen <= chars_seen + 1;
			if (expected_chars.size() == 0) begin
				$error("unexpected word: code_point %h malformed %b last_of_item %b",
					out_word.code_point, out_word.malformed, out_word.last_of_item);
				errors++;
			end else begin
				if (expected_chars[0].malformed)
					bad_chars++;
				if (out_word.code_point !== expected_chars[0].code_point) begin
					$error("code_point: expected %h, got %h",
						expected_chars[0].code_point, out_word.code_point);
					errors++;
				end
				if (out_word.malformed !== expected_chars[0].malformed) begin
					$error("malformed: expected %b, got %b",
						expected_chars[0].malformed, out_word.malformed);
					errors++;
				end
				if (out_word.last_of_item !== expected_chars[0].last_of_item) begin
					$error("last_of_item: expected %b, got %b",
						expected_chars[0].last_of_item, out_word.last_of_item);
					errors++;
				end
				void'(expected_chars.pop_front());
			end
		end
	end

	// watchdog
	initial begin
		#(20_000_000);
		$display("utf8_to_ucs2_decoder test failed");
		$finish;
	end

	initial begin
		seq_value = '0;
		conts_due = 2'd0;
		at_start = 1'b1;
		bom_lead = 1'b0;
		errors = 0;
		counted = 0;
		bytes_taken = 0;
		chars_seen = 0;
		bad_chars = 0;
		pair_bytes = 0;

		// directed: byte order mark at string start, then plain ascii extremes
		put_byte(8'hEF, 1'b0); put_byte(8'hBB, 1'b0); put_byte(8'hBF, 1'b0);
		put_byte(8'h00, 1'b0); put_byte(8'h7F, 1'b0);
		// two- and three-byte characters
		put_byte(8'hC3, 1'b0); put_byte(8'hA9, 1'b0);
		put_byte(8'hE2, 1'b0); put_byte(8'h82, 1'b0); put_byte(8'hAC, 1'b0);
		// mark value away from string start passes through
		put_byte(8'hEF, 1'b0); put_byte(8'hBB, 1'b0); put_byte(8'hBF, 1'b0);
		// four-byte lead with a stray continuation, invalid leads
		put_byte(8'hF0, 1'b0); put_byte(8'h9F, 1'b0);
		put_byte(8'hF8, 1'b0); put_byte(8'hFF, 1'b0);
		// sequence cut by a new byte
		put_byte(8'hC3, 1'b0); put_byte(8'h41, 1'b0);
		// surrogate passes unchecked, sequence cut by the string end
		put_byte(8'hED, 1'b0); put_byte(8'hA0, 1'b0); put_byte(8'h80, 1'b0);
		put_byte(8'hE2, 1'b0); put_byte(8'h82, 1'b1);
		// lead that is itself the last byte of a string
		put_byte(8'hDF, 1'b1);

		while (counted < 1950)
			add_string();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain stimulus, then outstanding characters, then a short settle
		do @(posedge clk); while (pending_bytes.size() != 0 || in_valid);
		do @(posedge clk); while (expected_chars.size() != 0);
		repeat (20) @(posedge clk);

		$display("bytes decoded: %0d, characters checked: %0d (%0d malformed)",
			bytes_taken, chars_seen, bad_chars);
		$display("bytes giving two characters: %0d, long output hold-off exercised: %0d",
			pair_bytes, hold_done);
		if (errors == 0)
			$display("utf8_to_ucs2_decoder test passed");
		else
			$display("utf8_to_ucs2_decoder test failed");
		$finish;
	end

endmodule
